// ===== hdl/lcadc_pkg.sv =====
`default_nettype none

package lcadc_pkg;

  // configuration register widths and reset values
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned TARE_W    = 24;
  localparam int unsigned TIMEOUT_W = 20;

  localparam logic [COUNT_W-1:0]   COUNT_RESET   = 8'd3;
  localparam logic [TARE_W-1:0]    TARE_RESET    = 24'd0;
  localparam logic                 APPLY_RESET   = 1'b1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd100000;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_READING_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_APPLY_TARE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_READY_TIMEOUT = 3'd3;

  // result value
  localparam int unsigned VALUE_W   = 25;
  localparam int unsigned VALUE_MAX = 16777215;

  // serial interface phase
  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_WAIT      = 6'b000010,
    PH_HIGH      = 6'b000100,
    PH_LOW       = 6'b001000,
    PH_GAIN_HIGH = 6'b010000,
    PH_GAIN_LOW  = 6'b100000
  } phase_e;

  // sequencer around the shared divide and adjust unit
  typedef enum logic [4:0] {
    SQ_TICK = 5'b00001,
    SQ_ABS  = 5'b00010,
    SQ_DIV  = 5'b00100,
    SQ_SIGN = 5'b01000,
    SQ_TARE = 5'b10000
  } seq_e;

endpackage

`default_nettype wire

// ===== hdl/load_cell_adc_reader_average_tare.sv =====
`default_nettype none

// Two-wire load-cell converter reader. Each input item is one microsecond tick
// (half a serial clock period) carrying the sampled data line and a start
// request; each tick gives one result item with the serial clock level to
// drive, busy, done and, on the done tick, the averaged reading minus the
// optional tare, saturated to 25 bits, plus a flag if any conversion hit the
// ready timeout. An ordinary tick's result sits in an output register, so the
// next tick is taken in the same cycle the result leaves. For the tick that
// completes a measurement, the sum of the readings is divided by the reading
// count in a restoring divider that produces one quotient bit per cycle
// (DATA_BITS + 8 bits), with magnitude, sign restore and tare subtract steps
// around it.
module load_cell_adc_reader_average_tare #(
  parameter int unsigned DATA_BITS = 24
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // tick channel
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire                                start_req_i,
  input  wire                                data_level_i,
  // result channel
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic                               clock_level_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic signed [lcadc_pkg::VALUE_W-1:0] value_o,
  output logic                               timed_out_o,
  // configuration
  input  wire                                cfg_we_i,
  input  wire  [lcadc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [lcadc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import lcadc_pkg::*;

  localparam int unsigned SUM_W  = DATA_BITS + COUNT_W;
  localparam int unsigned PI_W   = $clog2(DATA_BITS + 1);
  localparam int unsigned DC_W   = $clog2(SUM_W);
  localparam int unsigned AVG_W  = ((SUM_W > TARE_W) ? SUM_W : TARE_W) + 1;
  localparam logic signed [AVG_W-1:0] SAT_HI = AVG_W'(VALUE_MAX);
  localparam logic signed [AVG_W-1:0] SAT_LO = -SAT_HI;

  // configuration registers
  logic [COUNT_W-1:0]   count_q;
  logic [TARE_W-1:0]    tare_q;
  logic                 apply_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  // converter state
  phase_e                    phase_q, phase_d;
  logic [PI_W-1:0]           pulse_q, pulse_d;
  logic [DATA_BITS-1:0]      shift_q, shift_d;
  logic [TIMEOUT_W-1:0]      wait_q, wait_d;
  logic [COUNT_W-1:0]        rd_q, rd_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic                      tmo_q, tmo_d;

  // sequencer and shared unit
  seq_e                      seq_q, seq_d;
  logic [SUM_W-1:0]          dq_q, dq_d;
  logic [COUNT_W-1:0]        rem_q, rem_d;
  logic [DC_W-1:0]           dcnt_q, dcnt_d;
  logic                      neg_q, neg_d;

  // output register
  logic                      ovld_q, ovld_d;
  logic                      oclk_q, oclk_d;
  logic                      obusy_q, obusy_d;
  logic                      odone_q, odone_d;
  logic [VALUE_W-1:0]        oval_q, oval_d;
  logic                      otmo_q, otmo_d;

  // helpers
  logic                      tick_fire;
  logic [COUNT_W-1:0]        cnt_eff;
  logic signed [SUM_W-1:0]   reading;
  logic signed [SUM_W-1:0]   sum_new;
  logic [COUNT_W-1:0]        rd_new;
  logic                      more;
  logic [TIMEOUT_W:0]        wait_next;
  logic [PI_W-1:0]           pulse_next;
  logic [COUNT_W:0]          rem_sh;
  logic [COUNT_W:0]          rem_diff;
  logic                      qbit;
  logic signed [AVG_W-1:0]   quo_ext;
  logic signed [AVG_W-1:0]   tare_ext;
  logic signed [AVG_W-1:0]   avg;
  logic signed [AVG_W-1:0]   avg_sat;

  assign in_stall_o = (seq_q != SQ_TICK) || (ovld_q && out_stall_i);
  assign tick_fire  = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= COUNT_RESET;
      tare_q    <= TARE_RESET;
      apply_q   <= APPLY_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_READING_COUNT: count_q   <= cfg_data_i[COUNT_W-1:0];
        CFG_TARE_OFFSET:   tare_q    <= cfg_data_i[TARE_W-1:0];
        CFG_APPLY_TARE:    apply_q   <= cfg_data_i[0];
        CFG_READY_TIMEOUT: timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // conversion bookkeeping shared by the timeout and the gain pulse
  assign cnt_eff    = (count_q == '0) ? COUNT_W'(1) : count_q;
  assign reading    = (phase_q == PH_WAIT) ? '0 :
                      {{(SUM_W-DATA_BITS){shift_q[DATA_BITS-1]}}, shift_q};
  assign sum_new    = sum_q + reading;
  assign rd_new     = rd_q + COUNT_W'(1);
  assign more       = (rd_new < cnt_eff) && (rd_new != '0);
  assign wait_next  = {1'b0, wait_q} + (TIMEOUT_W+1)'(1);
  assign pulse_next = pulse_q + PI_W'(1);

  // divider step
  assign rem_sh   = {rem_q, dq_q[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, cnt_eff};
  assign qbit     = (rem_sh >= {1'b0, cnt_eff});

  // tare subtract and saturation
  assign quo_ext  = {{(AVG_W-SUM_W){dq_q[SUM_W-1]}}, dq_q};
  assign tare_ext = {{(AVG_W-TARE_W){tare_q[TARE_W-1]}}, tare_q};
  assign avg      = apply_q ? (quo_ext - tare_ext) : quo_ext;
  assign avg_sat  = (avg > SAT_HI) ? SAT_HI : ((avg < SAT_LO) ? SAT_LO : avg);

  always_comb begin
    logic conv_end;
    logic clk_lvl;
    logic busy;
    phase_d  = phase_q;
    pulse_d  = pulse_q;
    shift_d  = shift_q;
    wait_d   = wait_q;
    rd_d     = rd_q;
    sum_d    = sum_q;
    tmo_d    = tmo_q;
    seq_d    = seq_q;
    dq_d     = dq_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    neg_d    = neg_q;
    ovld_d   = ovld_q && out_stall_i;
    oclk_d   = oclk_q;
    obusy_d  = obusy_q;
    odone_d  = odone_q;
    oval_d   = oval_q;
    otmo_d   = otmo_q;
    conv_end = 1'b0;
    clk_lvl  = 1'b0;
    busy     = 1'b1;

    case (seq_q)
      // one tick of the serial interface
      SQ_TICK: begin
        if (tick_fire) begin
          case (phase_q)
            PH_IDLE: begin
              if (start_req_i) begin
                phase_d = PH_WAIT;
                wait_d  = '0;
                rd_d    = '0;
                sum_d   = '0;
                tmo_d   = 1'b0;
                pulse_d = '0;
                shift_d = '0;
              end else begin
                busy = 1'b0;
              end
            end
            PH_WAIT: begin
              if (!data_level_i) begin
                phase_d = PH_HIGH;
                pulse_d = '0;
                shift_d = '0;
              end else if (wait_next >= {1'b0, timeout_q}) begin
                tmo_d    = 1'b1;
                conv_end = 1'b1;
              end else begin
                wait_d = wait_next[TIMEOUT_W-1:0];
              end
            end
            PH_HIGH: begin
              clk_lvl = 1'b1;
              phase_d = PH_LOW;
            end
            PH_LOW: begin
              shift_d = {shift_q[DATA_BITS-2:0], data_level_i};
              pulse_d = pulse_next;
              phase_d = (pulse_next >= PI_W'(DATA_BITS)) ? PH_GAIN_HIGH : PH_HIGH;
            end
            PH_GAIN_HIGH: begin
              clk_lvl = 1'b1;
              phase_d = PH_GAIN_LOW;
            end
            PH_GAIN_LOW: begin
              conv_end = 1'b1;
            end
            default: begin
              phase_d = PH_IDLE;
              busy    = 1'b0;
            end
          endcase

          if (conv_end) begin
            sum_d = sum_new;
            rd_d  = rd_new;
            if (more) begin
              phase_d = PH_WAIT;
              wait_d  = '0;
            end else begin
              phase_d = PH_IDLE;
            end
          end

          if (conv_end && !more) begin
            // measurement complete: hand the sum to the divider
            dq_d  = sum_new;
            seq_d = SQ_ABS;
          end else begin
            ovld_d  = 1'b1;
            oclk_d  = clk_lvl;
            obusy_d = busy;
            odone_d = 1'b0;
            oval_d  = '0;
            otmo_d  = 1'b0;
          end
        end
      end
      // magnitude of the sum
      SQ_ABS: begin
        neg_d  = dq_q[SUM_W-1];
        dq_d   = dq_q[SUM_W-1] ? (~dq_q + SUM_W'(1)) : dq_q;
        rem_d  = '0;
        dcnt_d = DC_W'(SUM_W - 1);
        seq_d  = SQ_DIV;
      end
      // one quotient bit per cycle
      SQ_DIV: begin
        rem_d  = qbit ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        dq_d   = {dq_q[SUM_W-2:0], qbit};
        dcnt_d = dcnt_q - DC_W'(1);
        if (dcnt_q == '0) begin
          seq_d = SQ_SIGN;
        end
      end
      // restore the sign, truncating toward zero
      SQ_SIGN: begin
        dq_d  = neg_q ? (~dq_q + SUM_W'(1)) : dq_q;
        seq_d = SQ_TARE;
      end
      // tare, saturate and publish the done item
      SQ_TARE: begin
        ovld_d  = 1'b1;
        oclk_d  = 1'b0;
        obusy_d = 1'b0;
        odone_d = 1'b1;
        oval_d  = avg_sat[VALUE_W-1:0];
        otmo_d  = tmo_q;
        seq_d   = SQ_TICK;
      end
      default: begin
        seq_d = SQ_TICK;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pulse_q <= '0;
      shift_q <= '0;
      wait_q  <= '0;
      rd_q    <= '0;
      sum_q   <= '0;
      tmo_q   <= 1'b0;
      seq_q   <= SQ_TICK;
      ovld_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pulse_q <= pulse_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      rd_q    <= rd_d;
      sum_q   <= sum_d;
      tmo_q   <= tmo_d;
      seq_q   <= seq_d;
      ovld_q  <= ovld_d;
    end
  end

  // datapath and output payload
  always_ff @(posedge clk_i) begin
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    dcnt_q  <= dcnt_d;
    neg_q   <= neg_d;
    oclk_q  <= oclk_d;
    obusy_q <= obusy_d;
    odone_q <= odone_d;
    oval_q  <= oval_d;
    otmo_q  <= otmo_d;
  end

  assign out_valid_o   = ovld_q;
  assign clock_level_o = oclk_q;
  assign busy_res_o    = obusy_q;
  assign done_res_o    = odone_q;
  assign value_o       = oval_q;
  assign timed_out_o   = otmo_q;

  // divider remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_DIV) |-> (rem_q < cnt_eff))
    else $error("divider remainder not below divisor");

  // no result is pending while the divide sequence runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_ABS || seq_q == SQ_DIV || seq_q == SQ_SIGN || seq_q == SQ_TARE)
      |-> !ovld_q)
    else $error("result pending during divide sequence");

  // a pending done item means the converter is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && odone_q) |-> (phase_q == PH_IDLE))
    else $error("done item while converter busy");

  // last quotient bit hands over to the sign restore
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_DIV && dcnt_q == '0) |=> (seq_q == SQ_SIGN))
    else $error("divider did not finish on its last bit");

endmodule

`default_nettype wire

// ===== bench/load_cell_adc_reader_average_tare_test.sv =====
module load_cell_adc_reader_average_tare_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcadc_pkg::*;

  localparam int WORD_BITS  = 24;
  localparam int DONE_LAT   = WORD_BITS + 16;
  localparam int STALL_MAX  = 11;
  localparam int RAND_TICKS = 250;
  localparam int IDLE_LIMIT = 2000;
  localparam longint VAL_SAT = longint'(VALUE_MAX);

  // index outside the register map
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // how the converter words of a measurement are chosen
  localparam logic [1:0] WM_FIXED = 2'd0;
  localparam logic [1:0] WM_ALT   = 2'd1;
  localparam logic [1:0] WM_RAND  = 2'd2;

  typedef struct packed {
    logic                 clk;
    logic                 busy;
    logic                 done;
    logic [VALUE_W-1:0]   value;
    logic                 tmo;
  } tick_res_t;

  typedef struct packed {
    logic                 skip_cfg;
    logic [COUNT_W-1:0]   cnt;
    logic [TARE_W-1:0]    tare;
    logic                 apply;
    logic [TIMEOUT_W-1:0] tmo;
    logic [1:0]           mode;
    logic [WORD_BITS-1:0] word_a;
    logic [WORD_BITS-1:0] word_b;
    logic [7:0]           wait_lo;
    logic [7:0]           wait_hi;
    logic                 typed;
    logic [VALUE_W-1:0]   exp_value;
    logic                 exp_tmo;
  } meas_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  start_req_i = 1'b0;
  logic                  data_level_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  clock_level_o;
  logic                  busy_res_o;
  logic                  done_res_o;
  logic signed [VALUE_W-1:0] value_o;
  logic                  timed_out_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  load_cell_adc_reader_average_tare #(
    .DATA_BITS(WORD_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_req_i  (start_req_i),
    .data_level_i (data_level_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .clock_level_o(clock_level_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .value_o      (value_o),
    .timed_out_o  (timed_out_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // shadow configuration
  logic [COUNT_W-1:0]   count_cfg;
  logic [TARE_W-1:0]    tare_cfg;
  logic                 apply_cfg;
  logic [TIMEOUT_W-1:0] tmo_cfg;

  // shadow reader state
  phase_e               rd_phase;
  logic [4:0]           pulse_cnt;
  logic [WORD_BITS-1:0] shift_reg;
  logic [TIMEOUT_W-1:0] wait_cnt;
  logic [7:0]           readings_seen;
  logic signed [32:0]   sum_acc;
  logic                 tmo_seen;
  logic                 conv_begin;

  tick_res_t expected_ticks[$];
  int error_count = 0;
  int results_seen = 0;
  int tick_total = 0;

  // measurement profile used by the stimulus
  logic [1:0]           prof_mode;
  logic [WORD_BITS-1:0] prof_word_a;
  logic [WORD_BITS-1:0] prof_word_b;
  int                   prof_wait_lo;
  int                   prof_wait_hi;
  logic [WORD_BITS-1:0] word_now;
  int                   wait_left;
  logic                 src_calm = 1'b0;

  // typed expectation for the done tick of a directed row
  logic                 typed_on = 1'b0;
  logic [VALUE_W-1:0]   typed_value;
  logic                 typed_tmo;

  meas_row_t dir_rows [12];

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d",
             results_seen, field, got, want);
    error_count++;
  endtask

  task automatic clear_reader();
    count_cfg     = COUNT_RESET;
    tare_cfg      = TARE_RESET;
    apply_cfg     = APPLY_RESET;
    tmo_cfg       = TIMEOUT_RESET;
    rd_phase      = PH_IDLE;
    pulse_cnt     = '0;
    shift_reg     = '0;
    wait_cnt      = '0;
    readings_seen = '0;
    sum_acc       = '0;
    tmo_seen      = 1'b0;
    conv_begin    = 1'b0;
  endtask

  // add one reading; closes the measurement when the count is reached
  task automatic finish_reading(input logic signed [32:0] reading, output logic fin,
                                output logic [VALUE_W-1:0] val);
    logic [COUNT_W-1:0] cnt_eff;
    longint avg;
    cnt_eff = (count_cfg == '0) ? 8'd1 : count_cfg;
    sum_acc = sum_acc + reading;
    readings_seen = readings_seen + 8'd1;
    fin = 1'b0;
    val = '0;
    if (readings_seen < cnt_eff && readings_seen != 8'd0) begin
      rd_phase = PH_WAIT;
      wait_cnt = '0;
      conv_begin = 1'b1;
    end else begin
      avg = longint'(sum_acc) / longint'(cnt_eff);
      if (apply_cfg) avg = avg - longint'($signed(tare_cfg));
      if (avg > VAL_SAT) avg = VAL_SAT;
      if (avg < -VAL_SAT) avg = -VAL_SAT;
      val = avg[VALUE_W-1:0];
      fin = 1'b1;
      rd_phase = PH_IDLE;
    end
  endtask

  // expected result of one tick, advancing the shadow state
  task automatic predict_tick(input logic st, input logic dl, output tick_res_t r);
    int unsigned n;
    logic fin;
    logic [VALUE_W-1:0] v;
    r = '0;
    r.busy = 1'b1;
    fin = 1'b0;
    v = '0;
    conv_begin = 1'b0;
    case (rd_phase)
      PH_WAIT: begin
        if (!dl) begin
          rd_phase = PH_HIGH;
          pulse_cnt = '0;
          shift_reg = '0;
        end else begin
          n = wait_cnt + 1;
          if (n >= tmo_cfg) begin
            tmo_seen = 1'b1;
            finish_reading(33'sd0, fin, v);
          end else begin
            wait_cnt = n[TIMEOUT_W-1:0];
          end
        end
      end
      PH_HIGH: begin
        r.clk = 1'b1;
        rd_phase = PH_LOW;
      end
      PH_LOW: begin
        shift_reg = {shift_reg[WORD_BITS-2:0], dl};
        pulse_cnt = pulse_cnt + 5'd1;
        rd_phase = (pulse_cnt >= WORD_BITS) ? PH_GAIN_HIGH : PH_HIGH;
      end
      PH_GAIN_HIGH: begin
        r.clk = 1'b1;
        rd_phase = PH_GAIN_LOW;
      end
      PH_GAIN_LOW: begin
        finish_reading($signed(shift_reg), fin, v);
      end
      default: begin
        if (st) begin
          rd_phase = PH_WAIT;
          wait_cnt = '0;
          readings_seen = '0;
          sum_acc = '0;
          tmo_seen = 1'b0;
          pulse_cnt = '0;
          shift_reg = '0;
          conv_begin = 1'b1;
        end else begin
          rd_phase = PH_IDLE;
          r.busy = 1'b0;
        end
      end
    endcase
    if (fin) r.busy = 1'b0;
    r.done = fin;
    r.value = fin ? v : '0;
    r.tmo = fin & tmo_seen;
  endtask

  // pick the word and the ready delay of the next conversion
  task automatic new_conversion();
    case (prof_mode)
      WM_FIXED: word_now = prof_word_a;
      WM_ALT:   word_now = readings_seen[0] ? prof_word_b : prof_word_a;
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0: word_now = 24'h7FFFFF;
            1: word_now = 24'h800000;
            2: word_now = 24'h000000;
            default: word_now = 24'hFFFFFF;
          endcase
        end else begin
          word_now = WORD_BITS'($urandom);
        end
      end
    endcase
    wait_left = $urandom_range(prof_wait_hi, prof_wait_lo);
  endtask

  // offer one tick, wait for it to be taken, then predict its result
  task automatic send_tick(input logic st, input logic dl);
    int gap;
    tick_res_t r;
    gap = src_calm ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    start_req_i  <= st;
    data_level_i <= dl;
    do @(posedge clk_i); while (in_stall_o);
    predict_tick(st, dl, r);
    if (typed_on && r.done) begin
      r.value = typed_value;
      r.tmo = typed_tmo;
    end
    expected_ticks.push_back(r);
    tick_total++;
    if (conv_begin) new_conversion();
  endtask

  // one full measurement, from a few idle ticks to the done tick
  task automatic run_measurement();
    logic dl;
    logic st;
    repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'($urandom));
    send_tick(1'b1, 1'($urandom));
    while (rd_phase != PH_IDLE) begin
      case (rd_phase)
        PH_WAIT: begin
          dl = (wait_left > 0);
          if (wait_left > 0) wait_left--;
        end
        PH_LOW:  dl = word_now[WORD_BITS-1-pulse_cnt];
        default: dl = 1'($urandom);
      endcase
      // start requests while busy must be ignored
      st = ($urandom_range(0, 3) == 0);
      send_tick(st, dl);
    end
  endtask

  // let every result out, then allow for the done computation to settle
  task automatic drain_ticks();
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (DONE_LAT) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_READING_COUNT: count_cfg = data[COUNT_W-1:0];
      CFG_TARE_OFFSET:   tare_cfg  = data[TARE_W-1:0];
      CFG_APPLY_TARE:    apply_cfg = data[0];
      CFG_READY_TIMEOUT: tmo_cfg   = data[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [COUNT_W-1:0] cnt, input logic [TARE_W-1:0] tare,
                            input logic apl, input logic [TIMEOUT_W-1:0] tmo);
    logic [31:0] junk;
    junk = $urandom;
    // unused upper data bits carry noise
    cfg_write(CFG_READING_COUNT, {junk[15:0], cnt});
    cfg_write(CFG_TARE_OFFSET, tare);
    cfg_write(CFG_APPLY_TARE, {junk[22:0], apl});
    cfg_write(CFG_READY_TIMEOUT, {junk[27:24], tmo});
    // unmapped index, must change nothing
    cfg_write(CFG_UNUSED, junk[CFG_DATA_W-1:0]);
    cfg_we_i <= 1'b0;
  endtask

  // random register setting, mostly short measurements and short timeouts
  task automatic random_config();
    logic [COUNT_W-1:0] cnt;
    logic [TIMEOUT_W-1:0] tmo;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) cnt = COUNT_W'($urandom_range(1, 3));
    else if (pick < 17) cnt = '0;
    else cnt = COUNT_W'($urandom_range(4, 9));
    pick = $urandom_range(0, 19);
    if (pick < 12) tmo = TIMEOUT_W'($urandom_range(0, 12));
    else if (pick < 17) tmo = TIMEOUT_W'($urandom_range(13, 60));
    else if (pick < 19) tmo = TIMEOUT_RESET;
    else tmo = TIMEOUT_W'($urandom) | 20'hF0000;
    set_config(cnt, TARE_W'($urandom), 1'($urandom), tmo);
  endtask

  task automatic random_profile();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick < 4) prof_mode = WM_RAND;
    else if (pick == 4) prof_mode = WM_ALT;
    else prof_mode = WM_FIXED;
    prof_word_a = WORD_BITS'($urandom);
    prof_word_b = WORD_BITS'($urandom);
    prof_wait_lo = 0;
    prof_wait_hi = (tmo_cfg <= 60) ? int'(tmo_cfg) + 2 : 4;
    src_calm = ($urandom_range(0, 4) == 0);
  endtask

  // result side: random stall before each item, check against the oldest prediction
  int sink_left = 0;
  logic sink_calm = 1'b0;
  tick_res_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_ticks.size() == 0) begin
          report_mismatch("item with no tick pending", 1, 0);
        end else begin
          want = expected_ticks.pop_front();
          if (clock_level_o !== want.clk)
            report_mismatch("clock_level", clock_level_o, want.clk);
          if (busy_res_o !== want.busy)
            report_mismatch("busy", busy_res_o, want.busy);
          if (done_res_o !== want.done)
            report_mismatch("done", done_res_o, want.done);
          if (value_o !== want.value)
            report_mismatch("value", value_o, $signed(want.value));
          if (timed_out_o !== want.tmo)
            report_mismatch("timed_out", timed_out_o, want.tmo);
        end
        results_seen++;
        if (results_seen % 256 == 0) sink_calm = ($urandom_range(0, 3) == 0);
        sink_left = sink_calm ? 0 : $urandom_range(0, STALL_MAX);
      end else if (sink_left > 0) begin
        sink_left--;
      end
      out_stall_i <= (sink_left > 0);
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[load_cell_adc_reader_average_tare] ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int rand_base;
    meas_row_t row;
    // skip cnt tare apply tmo mode word_a word_b wait_lo wait_hi typed value tmo
    dir_rows = '{
      // reset settings, three small readings
      '{1'b1, 8'd3, 24'h000000, 1'b1, 20'd100000, WM_FIXED, 24'h000001, 24'h000000,
        8'd0, 8'd2, 1'b1, 25'sd1, 1'b0},
      // positive extreme after tare
      '{1'b0, 8'd1, 24'h800000, 1'b1, 20'd100, WM_FIXED, 24'h7FFFFF, 24'h000000,
        8'd0, 8'd3, 1'b1, 25'sd16777215, 1'b0},
      // negative extreme after tare
      '{1'b0, 8'd1, 24'h7FFFFF, 1'b1, 20'd100, WM_FIXED, 24'h800000, 24'h000000,
        8'd0, 8'd3, 1'b1, -25'sd16777215, 1'b0},
      // tare disabled, all-ones word
      '{1'b0, 8'd2, 24'h7FFFFF, 1'b0, 20'd50, WM_FIXED, 24'hFFFFFF, 24'h000000,
        8'd0, 8'd2, 1'b1, -25'sd1, 1'b0},
      // zero reading count acts as one
      '{1'b0, 8'd0, 24'h123456, 1'b0, 20'd50, WM_FIXED, 24'h7FFFFF, 24'h000000,
        8'd0, 8'd2, 1'b1, 25'sd8388607, 1'b0},
      // zero ready timeout, first high tick gives up
      '{1'b0, 8'd2, 24'h000000, 1'b0, 20'd0, WM_FIXED, 24'h000000, 24'h000000,
        8'd3, 8'd6, 1'b1, 25'sd0, 1'b1},
      // largest count, every conversion times out
      '{1'b0, 8'd255, 24'h000005, 1'b1, 20'd1, WM_FIXED, 24'h000000, 24'h000000,
        8'd2, 8'd4, 1'b1, -25'sd5, 1'b1},
      // division truncates toward zero
      '{1'b0, 8'd2, 24'h000000, 1'b0, 20'd100, WM_ALT, 24'hFFFFFF, 24'h000000,
        8'd0, 8'd2, 1'b1, 25'sd0, 1'b0},
      // largest timeout, negative sum
      '{1'b0, 8'd2, 24'hABCDEF, 1'b1, 20'hFFFFF, WM_ALT, 24'hFFFFFE, 24'h000000,
        8'd0, 8'd4, 1'b0, 25'sd0, 1'b0},
      // timeouts mixed with real readings
      '{1'b0, 8'd5, 24'h5A5A5A, 1'b1, 20'd3, WM_RAND, 24'h000000, 24'h000000,
        8'd0, 8'd5, 1'b0, 25'sd0, 1'b0},
      // full-scale readings average to full scale
      '{1'b0, 8'd2, 24'h000000, 1'b0, 20'd1000, WM_FIXED, 24'h7FFFFF, 24'h000000,
        8'd0, 8'd1, 1'b1, 25'sd8388607, 1'b0},
      '{1'b0, 8'd2, 24'h000001, 1'b1, 20'd8, WM_RAND, 24'h000000, 24'h000000,
        8'd0, 8'd2, 1'b0, 25'sd0, 1'b0}
    };

    clear_reader();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed measurements
    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      if (!row.skip_cfg) begin
        drain_ticks();
        set_config(row.cnt, row.tare, row.apply, row.tmo);
      end
      prof_mode    = row.mode;
      prof_word_a  = row.word_a;
      prof_word_b  = row.word_b;
      prof_wait_lo = int'(row.wait_lo);
      prof_wait_hi = int'(row.wait_hi);
      src_calm     = ($urandom_range(0, 3) == 0);
      typed_on     = row.typed;
      typed_value  = row.exp_value;
      typed_tmo    = row.exp_tmo;
      run_measurement();
      typed_on = 1'b0;
    end

    // random measurements with occasional register changes
    rand_base = tick_total;
    while (tick_total - rand_base < RAND_TICKS) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_ticks();
        random_config();
      end
      random_profile();
      run_measurement();
    end

    drain_ticks();
    if (error_count == 0 && expected_ticks.size() == 0) begin
      $display("[load_cell_adc_reader_average_tare] OK");
    end else begin
      $display("[load_cell_adc_reader_average_tare] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lcadc_pkg.sv
hdl/load_cell_adc_reader_average_tare.sv
bench/load_cell_adc_reader_average_tare_test.sv
